>>> rtl/ssram_pkg.sv
package ssram_pkg;

  // Memory geometry
  localparam int unsigned ADDR_BITS = 15;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_BITS  = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS  = $clog2(QDEPTH + 1);

  // Command codes
  localparam logic [7:0] CMD_WRITE_STATUS = 8'h01;
  localparam logic [7:0] CMD_WRITE        = 8'h02;
  localparam logic [7:0] CMD_READ         = 8'h03;
  localparam logic [7:0] CMD_READ_STATUS  = 8'h05;

  // Work the back part carries out for one transaction
  typedef enum logic [2:0] {
    OP_ZERO,
    OP_STAT_WR,
    OP_STAT_RD,
    OP_MEM_WR,
    OP_MEM_RD
  } op_kind_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [ADDR_BITS-1:0]  addr;
    logic [7:0]            data;
  } op_t;

endpackage

>>> rtl/spi_serial_sram_slave.sv
// Channel | Valid      | Stall       | Payload
// input   | in_valid_i | in_stall_o  | selected_i, byte_in_i
// output  | out_valid_o| out_stall_i | byte_out_o
//
// Each transaction yields one reply byte, which passes through the queue, the
// pending stage with the memory read, and the output register.
// The back part retires one operation per cycle through its single memory
// port, so throughput is one byte per cycle while the output is not stalled.
// Reset clears phase, address, status and the queue; memory is not cleared.
// The front stalls only when the four-entry queue is full.
module spi_serial_sram_slave (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       selected_i,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o
);

  import ssram_pkg::*;

  op_t  front_op;
  op_t  q_op;
  logic q_full, q_valid, q_pop;
  logic in_accept;

  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  ssram_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .selected_i (selected_i),
    .byte_in_i  (byte_in_i),
    .op_o       (front_op)
  );

  ssram_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_accept),
    .push_op_i (front_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (q_op)
  );

  ssram_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .byte_out_o  (byte_out_o)
  );

endmodule

>>> rtl/ssram_ram.sv
module ssram_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: write or registered read, read data holds otherwise
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ssram_front.sv
module ssram_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             selected_i,
  input  logic [7:0]       byte_in_i,
  output ssram_pkg::op_t   op_o
);

  import ssram_pkg::*;

  typedef enum logic [2:0] {
    PH_COMMAND,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_DATA,
    PH_STAT_WR,
    PH_STAT_RD,
    PH_IDLE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic                 rd_q, rd_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [15:0]          addr_hi_ext;

  assign addr_hi_ext = {byte_in_i, 8'h00};

  // Classify the byte and advance the command phase
  always_comb begin
    op_o.kind = OP_ZERO;
    op_o.addr = addr_q;
    op_o.data = byte_in_i;
    phase_d   = phase_q;
    rd_d      = rd_q;
    addr_d    = addr_q;
    if (!selected_i) begin
      phase_d = PH_COMMAND;
    end else begin
      unique case (phase_q)
        PH_COMMAND: begin
          rd_d = (byte_in_i == CMD_READ);
          if (byte_in_i == CMD_WRITE || byte_in_i == CMD_READ) begin
            phase_d = PH_ADDR_HI;
          end else if (byte_in_i == CMD_WRITE_STATUS) begin
            phase_d = PH_STAT_WR;
          end else if (byte_in_i == CMD_READ_STATUS) begin
            phase_d = PH_STAT_RD;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_ADDR_HI: begin
          addr_d  = addr_hi_ext[ADDR_BITS-1:0];
          phase_d = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          addr_d  = addr_q | ADDR_BITS'(byte_in_i);
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          op_o.kind = rd_q ? OP_MEM_RD : OP_MEM_WR;
          addr_d    = addr_q + 1'b1;
        end
        PH_STAT_WR: begin
          op_o.kind = OP_STAT_WR;
          phase_d   = PH_IDLE;
        end
        PH_STAT_RD: begin
          op_o.kind = OP_STAT_RD;
        end
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Hold phase, command kind and address pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COMMAND;
      rd_q    <= 1'b0;
      addr_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rd_q    <= rd_d;
      addr_q  <= addr_d;
    end
  end

endmodule

>>> rtl/ssram_fifo.sv
module ssram_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ssram_pkg::op_t   push_op_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ssram_pkg::op_t   pop_op_o
);

  import ssram_pkg::*;

  op_t                  entry_q [QDEPTH];
  logic [QPTR_BITS-1:0] wptr_q, rptr_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign full_o   = (cnt_q == QCNT_BITS'(QDEPTH));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = entry_q[rptr_q];

  // Store pushed operations
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_op_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ssram_back.sv
module ssram_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  ssram_pkg::op_t   q_op_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       byte_out_o
);

  import ssram_pkg::*;

  logic       p_valid_q;
  logic       p_rd_q;
  logic [7:0] p_data_q, p_data_d;
  logic [7:0] status_q;
  logic [7:0] ram_rdata;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       p_move;
  logic       mem_we, mem_re;

  // Pending stage moves when the output register is free or being drained
  assign p_move = p_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o  = q_valid_i && (!p_valid_q || p_move);
  assign mem_we = pop_o && (q_op_i.kind == OP_MEM_WR);
  assign mem_re = pop_o && (q_op_i.kind == OP_MEM_RD);

  ssram_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (q_op_i.addr),
    .wdata_i (q_op_i.data),
    .rdata_o (ram_rdata)
  );

  // Select the reply for non-memory operations
  always_comb begin
    unique case (q_op_i.kind)
      OP_STAT_RD: p_data_d = status_q;
      default:    p_data_d = 8'h00;
    endcase
  end

  // Execute status writes, hold the pending reply, drive the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= 8'h00;
      p_valid_q   <= 1'b0;
      p_rd_q      <= 1'b0;
      p_data_q    <= 8'h00;
      out_valid_q <= 1'b0;
      out_data_q  <= 8'h00;
    end else begin
      if (pop_o && q_op_i.kind == OP_STAT_WR) begin
        status_q <= q_op_i.data;
      end
      if (pop_o) begin
        p_valid_q <= 1'b1;
        p_rd_q    <= (q_op_i.kind == OP_MEM_RD);
        p_data_q  <= p_data_d;
      end else if (p_move) begin
        p_valid_q <= 1'b0;
      end
      if (p_move) begin
        out_valid_q <= 1'b1;
        out_data_q  <= p_rd_q ? ram_rdata : p_data_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = out_data_q;

endmodule

>>> rtl/ssram_checker.sv
module ssram_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] byte_out_o
);

  import ssram_pkg::*;

  localparam int unsigned CAPACITY = QDEPTH + 2;

  logic [3:0] outst_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track transactions accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_out_o))
    else $error("stalled reply changed or dropped");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outst_q != 4'd0)
    else $error("reply without an outstanding transaction");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= 4'(CAPACITY))
    else $error("more transactions in flight than storage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> outst_q >= 4'(QDEPTH))
    else $error("input stalled with queue room left");

endmodule

bind spi_serial_sram_slave ssram_checker u_ssram_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .byte_out_o  (byte_out_o)
);
